FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the sequence store.
// Each macro checks a property on the rising edge of clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property that must hold at every clock edge out of reset.
`define ISS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when the trigger holds, the consequence holds in the same cycle.
`define ISS_ASSERT_IMP(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/iss_pkg.sv
// Package of the indexed sequence store: request and status codes, field widths.
// Used by indexed_sequence_store; depends on nothing.
package iss_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 256;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 9;

  localparam logic [REQ_W-1:0] REQ_READ     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INS_AT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: design/indexed_sequence_store.sv
// Indexed sequence store: an ordered list of signed 32-bit values in one synchronous memory.
// Depends on iss_pkg and assert_macros.svh.
//
// The block keeps up to CAPACITY signed 32-bit values in order, plus a count of how many
// are stored. Each input item is one request: read at a position, insert at the head,
// insert at the tail, insert at a position (a position equal to the length appends), or
// delete at a position. Every item produces exactly one result item carrying a status
// (done, position out of range, store full), the length after the request and, for a
// read, the value; an out-of-range read returns -1 and all other requests return 0.
// Rejected requests leave the contents unchanged. The values live in a single memory
// with one write port and one registered read port, so inserts and deletes move the
// tail of the list one entry per cycle: each cycle a read of the next entry is issued
// while the entry fetched in the previous cycle is written one slot up (insert) or down
// (delete). How long an item keeps the block busy therefore depends on how much of the
// list moves: a read waits for its registered memory data, a delete shifts the entries
// above its slot down and then lowers the count, and an insert shifts the entries from
// its slot up and then writes the new value and raises the count. The next item is
// accepted once the previous result has been loaded into the output register, even
// while that result still waits there. No clearing pass runs after reset: entries are
// only ever read below the current length and all of those were written.
module indexed_sequence_store #(
  parameter int unsigned CAPACITY = iss_pkg::DEFAULT_CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [iss_pkg::REQ_W-1:0]          req_type_i,
  input  logic [iss_pkg::POS_W-1:0]          position_i,
  input  logic signed [iss_pkg::VAL_W-1:0]   new_value_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [iss_pkg::VAL_W-1:0]   read_value_o,
  output logic [iss_pkg::STATUS_W-1:0]       status_o,
  output logic [iss_pkg::LEN_W-1:0]          length_now_o
);

  // Address width of the memory and width of the element count.
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // Width used to compare a request position against the count.
  localparam int unsigned PW = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;
  localparam int unsigned VW = iss_pkg::VAL_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_PUT    = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_RES    = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           left_q, left_d;
  logic [AW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]           at_q, at_d;
  logic                    ins_q, ins_d;
  logic [VW-1:0]           val_q, val_d;
  logic                    pend_q, pend_d;
  logic [AW-1:0]           pend_addr_q, pend_addr_d;
  logic [VW-1:0]           hold_value_q, hold_value_d;
  logic [iss_pkg::STATUS_W-1:0] hold_status_q, hold_status_d;
  logic                    out_valid_q, out_valid_d;
  logic [VW-1:0]           out_value_q, out_value_d;
  logic [iss_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [iss_pkg::LEN_W-1:0] out_len_q, out_len_d;

  // Element memory with one write port and one registered read port.
  logic [VW-1:0]           element_store_q [CAPACITY];
  logic [VW-1:0]           rdata_q;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [VW-1:0]           mem_wdata;

  logic                    in_accept;
  logic                    full;
  logic [PW-1:0]           pos_ext;
  logic [PW-1:0]           cnt_ext;
  logic [CW-1:0]           ins_at;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign full = (count_q == CW'(CAPACITY));
  assign pos_ext = PW'(position_i);
  assign cnt_ext = PW'(count_q);

  // The only address the idle state ever reads is the requested position.
  assign rd_addr = (state_q == S_IDLE) ? AW'(position_i) : rd_ptr_q;

  // The new value goes in once the shift has drained; otherwise the entry fetched
  // in the previous cycle lands in its new slot.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr_q;
    mem_wdata = rdata_q;
    if (state_q == S_PUT) begin
      mem_we    = 1'b1;
      mem_waddr = at_q;
      mem_wdata = val_q;
    end else if (pend_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      element_store_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= element_store_q[rd_addr];
  end

  // Insert position for the three insert requests.
  always_comb begin
    case (req_type_i)
      iss_pkg::REQ_INS_HEAD: ins_at = '0;
      iss_pkg::REQ_INS_TAIL: ins_at = count_q;
      default:               ins_at = CW'(position_i);
    endcase
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    left_d        = left_q;
    rd_ptr_d      = rd_ptr_q;
    at_d          = at_q;
    ins_d         = ins_q;
    val_d         = val_q;
    pend_d        = 1'b0;
    pend_addr_d   = pend_addr_q;
    hold_value_d  = hold_value_q;
    hold_status_d = hold_status_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_value_d   = out_value_q;
    out_status_d  = out_status_q;
    out_len_d     = out_len_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          hold_value_d  = '0;
          hold_status_d = iss_pkg::ST_DONE;
          state_d       = S_RES;
          val_d         = new_value_i;
          unique case (req_type_i) inside
            iss_pkg::REQ_READ: begin
              if (pos_ext < cnt_ext) begin
                state_d = S_RDWAIT;
              end else begin
                hold_value_d  = '1;
                hold_status_d = iss_pkg::ST_RANGE;
              end
            end
            iss_pkg::REQ_INS_HEAD, iss_pkg::REQ_INS_TAIL, iss_pkg::REQ_INS_AT: begin
              if (req_type_i == iss_pkg::REQ_INS_AT && pos_ext > cnt_ext) begin
                hold_status_d = iss_pkg::ST_RANGE;
              end else if (full) begin
                hold_status_d = iss_pkg::ST_FULL;
              end else begin
                // Entries from the insert slot up to the tail move up by one.
                ins_d    = 1'b1;
                at_d     = AW'(ins_at);
                left_d   = count_q - ins_at;
                rd_ptr_d = AW'(count_q - CW'(1));
                state_d  = S_SHIFT;
              end
            end
            iss_pkg::REQ_DELETE: begin
              if (pos_ext < cnt_ext) begin
                // Entries above the deleted slot move down by one.
                ins_d    = 1'b0;
                left_d   = count_q - CW'(1) - CW'(position_i);
                rd_ptr_d = AW'(position_i) + AW'(1);
                state_d  = S_SHIFT;
              end else begin
                hold_status_d = iss_pkg::ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (left_q != '0) begin
          pend_d      = 1'b1;
          pend_addr_d = ins_q ? (rd_ptr_q + AW'(1)) : (rd_ptr_q - AW'(1));
          rd_ptr_d    = ins_q ? (rd_ptr_q - AW'(1)) : (rd_ptr_q + AW'(1));
          left_d      = left_q - CW'(1);
        end else if (ins_q) begin
          state_d = S_PUT;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_RES;
        end
      end
      S_PUT: begin
        count_d = count_q + CW'(1);
        state_d = S_RES;
      end
      S_RDWAIT: begin
        hold_value_d = rdata_q;
        state_d      = S_RES;
      end
      S_RES: begin
        // Wait until the output register is free or is being emptied this cycle.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_value_d  = hold_value_q;
          out_status_d = hold_status_q;
          out_len_d    = iss_pkg::LEN_W'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q        <= left_d;
    rd_ptr_q      <= rd_ptr_d;
    at_q          <= at_d;
    ins_q         <= ins_d;
    val_q         <= val_d;
    pend_addr_q   <= pend_addr_d;
    hold_value_q  <= hold_value_d;
    hold_status_q <= hold_status_d;
    out_value_q   <= out_value_d;
    out_status_q  <= out_status_d;
    out_len_q     <= out_len_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;
  assign length_now_o = out_len_q;

`include "assert_macros.svh"

  `ISS_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "element count above capacity")
  `ISS_ASSERT_IMP(a_put_no_pend, state_q == S_PUT, !pend_q, "new value collides with shift write")
  `ISS_ASSERT_IMP(a_count_step, !$stable(count_q), (count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)), "element count moved by more than one")
  `ISS_ASSERT_IMP(a_out_from_res, $rose(out_valid_q), $past(state_q) == S_RES, "result loaded outside the result state")

endmodule
